>>> rtl/glr_pkg.sv
// Shared types, constants and calibration tables for the gas sensor ratio linearizer.
// No dependencies.
package glr_pkg;

	localparam int RES_BITS_DEF  = 24;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SEL_BITS      = 4;
	localparam int NUM_SEL       = 16;
	localparam int COEF_FRAC     = 24;
	localparam int LOG2_FRAC     = 30;
	localparam int MANT_BITS     = 32;
	localparam int VAL_BITS      = 32;
	localparam int IPART_BITS    = 6;
	localparam logic [26:0] LOG10_2_Q28 = 27'd80807124;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_BASE_ZERO  = 2'd1,
		STAT_SENSE_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic [SEL_BITS-1:0] sel;
		status_t             status;
		logic                in_range;
	} side_t;

	typedef int milli_tab_t [NUM_SEL];
	typedef logic signed [31:0] coef_t;
	typedef coef_t coef_tab_t [NUM_SEL];
	typedef logic [31:0] bound_tab_t [NUM_SEL];

	// calibration in thousandths; selectors 9..15 are unused and read zero
	localparam milli_tab_t LO_MILLI = '{2280, 1440, 657, 204, 150, 681, 321, 783, 2050,
		0, 0, 0, 0, 0, 0, 0};
	localparam milli_tab_t HI_MILLI = '{3850, 3460, 1750, 949, 705, 3060, 2050, 1600, 7870,
		0, 0, 0, 0, 0, 0, 0};
	localparam milli_tab_t A_MILLI = '{17700, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0};
	localparam milli_tab_t B_MILLI = '{-23500, -4500, -3830, -2550, -2480, -2590, -2110,
		-2220, -2260, 0, 0, 0, 0, 0, 0, 0};
	localparam milli_tab_t C_MILLI = '{10000, 4810, 3070, 2250, 1900, 3590, 2970, 2740,
		2700, 0, 0, 0, 0, 0, 0, 0};

	// thousandths to fixed point: magnitude rounded half up, then sign applied
	function automatic longint milli_fix(int m, int f);
		longint mag;
		longint q;
		mag = (m < 0) ? -longint'(m) : longint'(m);
		q = ((mag <<< f) + 500) / 1000;
		return (m < 0) ? -q : q;
	endfunction

	function automatic coef_tab_t coef_table(milli_tab_t m);
		coef_tab_t t;
		for (int i = 0; i < NUM_SEL; i++) begin
			t[i] = coef_t'(milli_fix(m[i], COEF_FRAC));
		end
		return t;
	endfunction

	function automatic bound_tab_t bound_table(milli_tab_t m, int f);
		bound_tab_t t;
		for (int i = 0; i < NUM_SEL; i++) begin
			t[i] = 32'(milli_fix(m[i], f));
		end
		return t;
	endfunction

endpackage

>>> rtl/glr_div.sv
// Restoring divider pipeline: ratio sensed/baseline in unsigned 8.FRAC_BITS,
// saturated, with zero checks and the calibrated bound test. Uses glr_pkg.
module glr_div
	import glr_pkg::*;
#(
	parameter int RES_BITS  = RES_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [SEL_BITS-1:0]       in_sel,
	input  logic [RES_BITS-1:0]       sense,
	input  logic [RES_BITS-1:0]       base,
	output logic                      out_valid,
	output side_t                     out_side,
	output logic [8+FRAC_BITS-1:0]    out_x
);

	localparam int QW = 8 + FRAC_BITS;
	localparam bound_tab_t LO_TAB = bound_table(LO_MILLI, FRAC_BITS);
	localparam bound_tab_t HI_TAB = bound_table(HI_MILLI, FRAC_BITS);

	logic                v_s   [0:QW];
	side_t               sd_s  [0:QW];
	logic [RES_BITS-1:0] rem_s [0:QW];
	logic [RES_BITS-1:0] den_s [0:QW];
	logic [QW-1:0]       q_s   [0:QW];
	logic [7:0]          lb_s  [0:QW];
	logic                ovf_s [0:QW];

	logic [RES_BITS:0]   trial [0:QW-1];
	logic [RES_BITS-1:0] rem_n [0:QW-1];
	logic [QW-1:0]       q_n   [0:QW-1];

	side_t               sd_in;
	logic [QW-1:0]       x_c;
	side_t               sd_c;

	always_comb begin
		sd_in.sel = in_sel;
		sd_in.in_range = 1'b0;
		if (base == '0) begin
			sd_in.status = STAT_BASE_ZERO;
		end else if (sense == '0) begin
			sd_in.status = STAT_SENSE_ZERO;
		end else begin
			sd_in.status = STAT_OK;
		end
	end

	// one quotient bit per stage, MSB first; bits above QW are zero or else flagged as overflow
	always_comb begin
		int bi;
		logic nbit;
		logic ge;
		for (int k = 0; k < QW; k++) begin
			bi = QW - 1 - k;
			nbit = (bi >= FRAC_BITS) ? lb_s[k][3'(bi - FRAC_BITS)] : 1'b0;
			trial[k] = {rem_s[k], nbit};
			ge = trial[k] >= {1'b0, den_s[k]};
			rem_n[k] = ge ? RES_BITS'(trial[k] - {1'b0, den_s[k]}) : RES_BITS'(trial[k]);
			q_n[k] = {q_s[k][QW-2:0], ge};
		end
	end

	always_comb begin
		x_c = ovf_s[QW] ? {QW{1'b1}} : q_s[QW];
		if (x_c == '0) begin
			x_c = QW'(1);
		end
		sd_c = sd_s[QW];
		sd_c.in_range = (32'(x_c) > LO_TAB[sd_s[QW].sel]) && (32'(x_c) < HI_TAB[sd_s[QW].sel]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) begin
				v_s[k] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int k = 0; k < QW; k++) begin
				v_s[k+1] <= v_s[k];
			end
			out_valid <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		sd_s[0]  <= sd_in;
		rem_s[0] <= sense >> 8;
		den_s[0] <= base;
		q_s[0]   <= '0;
		lb_s[0]  <= sense[7:0];
		ovf_s[0] <= {8'd0, sense} >= {base, 8'd0};
		for (int k = 0; k < QW; k++) begin
			sd_s[k+1]  <= sd_s[k];
			rem_s[k+1] <= rem_n[k];
			den_s[k+1] <= den_s[k];
			q_s[k+1]   <= q_n[k];
			lb_s[k+1]  <= lb_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
		out_side <= sd_c;
		out_x    <= x_c;
	end

endmodule

>>> rtl/glr_log.sv
// log10 pipeline: normalize, 30 squaring stages for the log2 fraction,
// then scale by log10(2) in two partial products. Uses glr_pkg.
module glr_log
	import glr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  side_t                      in_side,
	input  logic [8+FRAC_BITS-1:0]     in_x,
	output logic                       out_valid,
	output side_t                      out_side,
	output logic signed [VAL_BITS-1:0] out_log
);

	localparam int L2W = IPART_BITS + LOG2_FRAC;
	localparam int LOW = 18;
	localparam int HIW = L2W - LOW;

	logic                         v_s  [0:LOG2_FRAC];
	side_t                        sd_s [0:LOG2_FRAC];
	logic [MANT_BITS-1:0]         m_s  [0:LOG2_FRAC];
	logic [LOG2_FRAC-1:0]         fr_s [0:LOG2_FRAC];
	logic signed [IPART_BITS-1:0] ip_s [0:LOG2_FRAC];

	logic [MANT_BITS-1:0]         m_n  [0:LOG2_FRAC-1];
	logic [LOG2_FRAC-1:0]         fr_n [0:LOG2_FRAC-1];

	logic [MANT_BITS-1:0]         norm_m;
	logic [4:0]                   norm_lz;
	logic signed [IPART_BITS-1:0] ip_c;

	logic                         v_pa;
	side_t                        sd_pa;
	logic signed [HIW+27:0]       phi_pa;
	logic [LOW+26:0]              plo_pa;

	logic signed [L2W-1:0]        l2_c;
	logic signed [63:0]           tot_c;

	// leading-one search as a five-step binary shift
	always_comb begin
		norm_m = MANT_BITS'(in_x);
		norm_lz = '0;
		for (int s = 4; s >= 0; s--) begin
			if ((norm_m >> (MANT_BITS - (1 << s))) == '0) begin
				norm_m = norm_m << (1 << s);
				norm_lz = norm_lz + 5'(1 << s);
			end
		end
		ip_c = IPART_BITS'(MANT_BITS - 1 - FRAC_BITS - int'(norm_lz));
	end

	always_comb begin
		logic [63:0] sq;
		logic [32:0] t;
		for (int j = 0; j < LOG2_FRAC; j++) begin
			sq = 64'(m_s[j]) * 64'(m_s[j]);
			t = 33'(sq >> 31);
			if (t[32]) begin
				m_n[j] = t[32:1];
				fr_n[j] = {fr_s[j][LOG2_FRAC-2:0], 1'b1};
			end else begin
				m_n[j] = t[31:0];
				fr_n[j] = {fr_s[j][LOG2_FRAC-2:0], 1'b0};
			end
		end
	end

	assign l2_c = {ip_s[LOG2_FRAC], fr_s[LOG2_FRAC]};
	assign tot_c = (64'(phi_pa) <<< LOW) + $signed(64'(plo_pa));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= LOG2_FRAC; j++) begin
				v_s[j] <= 1'b0;
			end
			v_pa <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int j = 0; j < LOG2_FRAC; j++) begin
				v_s[j+1] <= v_s[j];
			end
			v_pa <= v_s[LOG2_FRAC];
			out_valid <= v_pa;
		end
	end

	always_ff @(posedge clk) begin
		sd_s[0] <= in_side;
		m_s[0]  <= norm_m;
		fr_s[0] <= '0;
		ip_s[0] <= ip_c;
		for (int j = 0; j < LOG2_FRAC; j++) begin
			sd_s[j+1] <= sd_s[j];
			m_s[j+1]  <= m_n[j];
			fr_s[j+1] <= fr_n[j];
			ip_s[j+1] <= ip_s[j];
		end
		sd_pa  <= sd_s[LOG2_FRAC];
		phi_pa <= $signed(l2_c[L2W-1:LOW]) * $signed({1'b0, LOG10_2_Q28});
		plo_pa <= l2_c[LOW-1:0] * LOG10_2_Q28;
		out_side <= sd_pa;
		out_log  <= VAL_BITS'(tot_c >>> 34);
	end

endmodule

>>> rtl/glr_poly.sv
// Quadratic in log10 of the ratio: square, coefficient products, sum,
// round and saturate, zero-case override. Uses glr_pkg.
module glr_poly
	import glr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  side_t                      in_side,
	input  logic signed [VAL_BITS-1:0] in_log,
	output logic                       out_valid,
	output logic                       out_in_range,
	output logic signed [VAL_BITS-1:0] out_value,
	output status_t                    out_status
);

	localparam int SH = 2 * COEF_FRAC - FRAC_BITS;
	localparam coef_tab_t A_TAB = coef_table(A_MILLI);
	localparam coef_tab_t B_TAB = coef_table(B_MILLI);
	localparam coef_tab_t C_TAB = coef_table(C_MILLI);
	localparam logic signed [63:0] VMAX = 64'sd2147483647;
	localparam logic signed [63:0] VMIN = -64'sd2147483648;

	logic                       v_s1, v_s2, v_s3;
	side_t                      sd_s1, sd_s2, sd_s3;
	logic signed [VAL_BITS-1:0] l_s1, l2_s1;
	logic signed [63:0]         pa_s2, pb_s2, sum_s3;
	logic signed [VAL_BITS-1:0] c_s2;

	logic signed [63:0]         sq_c;
	logic signed [63:0]         r_c;
	logic signed [VAL_BITS-1:0] v_c;

	assign sq_c = 64'(in_log) * 64'(in_log);

	always_comb begin
		r_c = (sum_s3 + (64'sd1 <<< (SH - 1))) >>> SH;
		if (r_c > VMAX) begin
			v_c = VMAX[VAL_BITS-1:0];
		end else if (r_c < VMIN) begin
			v_c = VMIN[VAL_BITS-1:0];
		end else begin
			v_c = r_c[VAL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sd_s1 <= in_side;
		l_s1  <= in_log;
		l2_s1 <= VAL_BITS'(sq_c >>> COEF_FRAC);
		sd_s2 <= sd_s1;
		pa_s2 <= 64'(A_TAB[sd_s1.sel]) * 64'(l2_s1);
		pb_s2 <= 64'(B_TAB[sd_s1.sel]) * 64'(l_s1);
		c_s2  <= C_TAB[sd_s1.sel];
		sd_s3 <= sd_s2;
		sum_s3 <= pa_s2 + pb_s2 + (64'(c_s2) <<< COEF_FRAC);
		out_status <= sd_s3.status;
		if (sd_s3.status == STAT_OK) begin
			out_in_range <= sd_s3.in_range;
			out_value    <= v_c;
		end else begin
			out_in_range <= 1'b0;
			out_value    <= '0;
		end
	end

endmodule

>>> rtl/gas_sensor_ratio_linearizer.sv
// Gas sensor ratio linearizer, top level. The pipeline is built from
// a restoring divider with one quotient bit per stage, 30 squaring stages for log2,
// and a four-stage polynomial. Throughput one item per cycle; busy stays low.
// Results appear for one cycle with done; the receiver cannot stall.
// arst_n clears all valid bits; payload registers are not reset.
module gas_sensor_ratio_linearizer
	import glr_pkg::*;
#(
	parameter int RES_BITS  = RES_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [SEL_BITS-1:0]        curve_select,
	input  logic [RES_BITS-1:0]        sense_resistance,
	input  logic [RES_BITS-1:0]        base_resistance,
	output logic                       done,
	output logic                       in_range,
	output logic signed [VAL_BITS-1:0] curve_value,
	output logic [1:0]                 status
);

	logic                       div_valid;
	side_t                      div_side;
	logic [8+FRAC_BITS-1:0]     div_x;
	logic                       log_valid;
	side_t                      log_side;
	logic signed [VAL_BITS-1:0] log_val;
	status_t                    stat;

	assign busy = 1'b0;
	assign status = stat;

	glr_div #(.RES_BITS(RES_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_sel    (curve_select),
		.sense     (sense_resistance),
		.base      (base_resistance),
		.out_valid (div_valid),
		.out_side  (div_side),
		.out_x     (div_x)
	);

	glr_log #(.FRAC_BITS(FRAC_BITS)) u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_side   (div_side),
		.in_x      (div_x),
		.out_valid (log_valid),
		.out_side  (log_side),
		.out_log   (log_val)
	);

	glr_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (log_valid),
		.in_side      (log_side),
		.in_log       (log_val),
		.out_valid    (done),
		.out_in_range (in_range),
		.out_value    (curve_value),
		.out_status   (stat)
	);

endmodule

>>> test/tb.sv
// Self-checking bench for gas_sensor_ratio_linearizer: random and directed ratios are
// checked against a bit-exact model of the ratio, log10 and quadratic curve.
// Depends on glr_pkg and the top level RTL.
`timescale 1ns / 1ps

module tb;
	import glr_pkg::*;

	typedef struct packed {
		logic [3:0]  sel;
		logic [23:0] rs;
		logic [23:0] r0;
	} gas_item_t;

	typedef struct packed {
		logic        in_rng;
		logic [31:0] value;
		status_t     stat;
	} curve_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [3:0]  curve_select = '0;
	logic [23:0] sense_resistance = '0;
	logic [23:0] base_resistance = '0;
	logic        done;
	logic        in_range;
	logic signed [31:0] curve_value;
	logic [1:0]  status;

	gas_item_t  pending_items[$];
	curve_res_t awaited_results[$];
	int         n_errors = 0;
	int         n_checked = 0;
	int         n_sent = 0;
	int         n_inrange = 0;
	int         cycles = 0;
	bit         took = 1'b0;
	bit         feeding = 1'b0;

	// calibration, thousandths
	int lo_k[16] = '{2280, 1440, 657, 204, 150, 681, 321, 783, 2050, 0, 0, 0, 0, 0, 0, 0};
	int hi_k[16] = '{3850, 3460, 1750, 949, 705, 3060, 2050, 1600, 7870, 0, 0, 0, 0, 0, 0, 0};
	int a_k[16]  = '{17700, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	int b_k[16]  = '{-23500, -4500, -3830, -2550, -2480, -2590, -2110, -2220, -2260,
		0, 0, 0, 0, 0, 0, 0};
	int c_k[16]  = '{10000, 4810, 3070, 2250, 1900, 3590, 2970, 2740, 2700,
		0, 0, 0, 0, 0, 0, 0};

	gas_sensor_ratio_linearizer i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.curve_select(curve_select), .sense_resistance(sense_resistance),
		.base_resistance(base_resistance), .done(done), .in_range(in_range),
		.curve_value(curve_value), .status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint thousandths_to_fixed(int k, int fbits);
		longint mag;
		longint q;
		mag = (k < 0) ? -longint'(k) : longint'(k);
		q = ((mag << fbits) + 500) / 1000;
		return (k < 0) ? -q : q;
	endfunction

	// log10 of nonzero Q8.16 ratio, Q.24
	function automatic longint ratio_log10(longint x);
		int p;
		longint unsigned m;
		longint frac;
		longint l2;
		p = 31;
		frac = 0;
		while (p > 0 && x[p] == 1'b0)
			p--;
		m = (longint'(x) << (31 - p)) & 64'hFFFF_FFFF;
		for (int i = 0; i < 30; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		l2 = (longint'(p - 16) <<< 30) + frac;
		return (l2 * 64'sd80807124) >>> 34;
	endfunction

	function automatic curve_res_t linearize(gas_item_t it);
		curve_res_t r;
		longint x, lg, lg2, sum, v;
		r = '{in_rng: 1'b0, value: 32'd0, stat: STAT_OK};
		if (it.r0 == 0) begin
			r.stat = STAT_BASE_ZERO;
			return r;
		end
		if (it.rs == 0) begin
			r.stat = STAT_SENSE_ZERO;
			return r;
		end
		x = (longint'(it.rs) << 16) / longint'(it.r0);
		if (x > 64'hFF_FFFF) x = 64'hFF_FFFF;
		if (x == 0) x = 1;
		r.in_rng = (x > thousandths_to_fixed(lo_k[it.sel], 16)) &&
			(x < thousandths_to_fixed(hi_k[it.sel], 16));
		lg = ratio_log10(x);
		lg2 = (lg * lg) >>> 24;
		sum = thousandths_to_fixed(a_k[it.sel], 24) * lg2
			+ thousandths_to_fixed(b_k[it.sel], 24) * lg
			+ (thousandths_to_fixed(c_k[it.sel], 24) <<< 24);
		v = (sum + (64'sd1 <<< 31)) >>> 32;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		else if (v > 64'sd2147483647) v = 64'sd2147483647;
		r.value = v[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		n_errors++;
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_checked);
	endtask

	// driver: new item or idle at each falling edge after the last one was taken
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_items.size() > 0 &&
				((n_sent >= 150 && n_sent < 260) || $urandom_range(99) >= 11)) begin
				gas_item_t it;
				it = pending_items.pop_front();
				start <= 1'b1;
				curve_select <= it.sel;
				sense_resistance <= it.rs;
				base_resistance <= it.r0;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: record accepted items, check results
	always @(posedge clk) begin
		cycles++;
		took = 1'b0;
		if (arst_n && start && !busy) begin
			gas_item_t it;
			it = '{sel: curve_select, rs: sense_resistance, r0: base_resistance};
			awaited_results.push_back(linearize(it));
			took = 1'b1;
			n_sent++;
		end
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result", curve_value, 0);
			end else begin
				curve_res_t e;
				e = awaited_results.pop_front();
				if (in_range !== e.in_rng) report_mismatch("in_range", in_range, e.in_rng);
				if (curve_value !== e.value)
					report_mismatch("curve_value", curve_value, $signed(e.value));
				if (status !== e.stat) report_mismatch("status", status, e.stat);
				if (e.in_rng) n_inrange++;
				n_checked++;
			end
		end
		if (cycles > 300000) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic add_item(int sel, int rs, int r0);
		pending_items.push_back('{sel: 4'(sel), rs: 24'(rs), r0: 24'(r0)});
	endtask

	initial begin
		int base, k, rs;
		// zero operands, extreme ratios, a tiny ratio clamped to one LSB
		add_item(0, 0, 0);
		add_item(1, 0, 5000);
		add_item(2, 5000, 0);
		add_item(15, 24'hFFFFFF, 24'hFFFFFF);
		add_item(0, 24'hFFFFFF, 1);
		add_item(8, 1, 24'hFFFFFF);
		add_item(3, 24'hAAAAAA, 24'h555555);
		add_item(4, 24'h555555, 24'hAAAAAA);
		// every selector, plus exact bound ratios
		for (int s = 0; s < 16; s++)
			add_item(s, 1500 + 300 * s, 1000);
		add_item(0, 2280, 1000);
		add_item(0, 3850, 1000);
		while (pending_items.size() > 0 || awaited_results.size() > 0) @(posedge clk);
		repeat (9) @(posedge clk);
		for (int i = 0; i < 400; i++) begin
			k = $urandom_range(99);
			if (k < 5) begin
				add_item($urandom_range(15), $urandom_range(1) ? 0 : $urandom,
					$urandom_range(1) ? 0 : $urandom);
			end else if (k < 20) begin
				add_item($urandom_range(15), $urandom, $urandom);
			end else begin
				// ratios around the calibrated spans, mostly valid curves
				base = $urandom_range(24'hFFFFFF, 1);
				rs = int'((longint'(base) * $urandom_range(9000)) >> 10);
				if (rs > 24'hFFFFFF) rs = 24'hFFFFFF;
				add_item($urandom_range(99) < 85 ? $urandom_range(8) : $urandom_range(15),
					rs, base);
			end
		end
		while (pending_items.size() > 0 || awaited_results.size() > 0) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("checked %0d results of %0d items (%0d in range)", n_checked, n_sent,
			n_inrange);
		if (n_errors == 0 && awaited_results.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// reset asserted from time zero, released on a falling edge
	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
	end

endmodule

>>> gas_sensor_ratio_linearizer.f
rtl/glr_pkg.sv
rtl/glr_div.sv
rtl/glr_log.sv
rtl/glr_poly.sv
rtl/gas_sensor_ratio_linearizer.sv
test/tb.sv
